FILE: hdl/upd_pkg.sv
`default_nettype none

package upd_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_PCT   = 8'h25;  // '%'
    localparam logic [7:0] CH_TWO   = 8'h32;  // '2'
    localparam logic [7:0] CH_FIVE  = 8'h35;  // '5'
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CODE_PCT = 8'h25;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PCT,
        PH_HEX1,
        PH_AFTER25,
        PH_HELD2,
        PH_DROP
    } t_phase;

    // One decoded result
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       decode_error;
        logic       last_of_string;
    } t_result;

    // Work for the back end from one accepted item: an optional held '2'
    // followed by an optional main result.
    typedef struct packed {
        logic    pre_two;
        logic    main_present;
        t_result main;
    } t_entry;

    // Bit 4 set: not a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] h;
        h = 5'h10;
        if (b >= 8'h30 && b <= 8'h39) begin
            h = {1'b0, b[3:0]};
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            h = {1'b0, b[3:0] + 4'd9};
        end
        return h;
    endfunction

    function automatic logic code_ok(input logic [7:0] v);
        logic ok;
        ok = 1'b0;
        if (v == 8'h0A || v == 8'h0D) begin
            ok = 1'b1;
        end else if (v >= 8'h20 && v <= 8'h7E) begin
            ok = 1'b1;
        end else if (v[7]) begin
            ok = !(v == 8'h81 || v == 8'h8D || v == 8'h8F || v == 8'h90 ||
                   v == 8'h9D || v == 8'hAD || v == 8'hFE);
        end
        return ok;
    endfunction

    function automatic logic [7:0] code_map(input logic [7:0] v);
        return (v == 8'h0D) ? CH_LF : v;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/upd_front.sv
`default_nettype none

// Escape tracker: classifies each accepted byte, builds queue entries.
module upd_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire logic [7:0]      i_in_byte,
    input  wire logic            i_end_of_string,
    output upd_pkg::t_entry      o_entry,
    output logic                 o_push
);

    upd_pkg::t_phase r_phase, n_phase;
    logic [3:0]      r_hex, n_hex;
    upd_pkg::t_entry ent;
    logic [4:0]      h;
    logic [7:0]      code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= upd_pkg::PH_IDLE;
            r_hex   <= 4'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_hex   <= n_hex;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_hex   = r_hex;
        h       = upd_pkg::hex_value(i_in_byte);
        code    = {r_hex, h[3:0]};
        ent     = '0;
        ent.main.last_of_string = i_end_of_string;

        case (r_phase)
            upd_pkg::PH_PCT: begin
                if (h[4] || i_end_of_string) begin
                    ent.main_present      = 1'b1;
                    ent.main.decode_error = 1'b1;
                    n_phase               = upd_pkg::PH_DROP;
                end else begin
                    n_hex   = h[3:0];
                    n_phase = upd_pkg::PH_HEX1;
                end
            end
            upd_pkg::PH_HEX1: begin
                ent.main_present = 1'b1;
                if (h[4]) begin
                    ent.main.decode_error = 1'b1;
                    n_phase               = upd_pkg::PH_DROP;
                end else if (code == upd_pkg::CODE_PCT) begin
                    ent.main.out_byte   = upd_pkg::CH_PCT;
                    ent.main.byte_valid = 1'b1;
                    n_phase             = upd_pkg::PH_AFTER25;
                end else if (upd_pkg::code_ok(code)) begin
                    ent.main.out_byte   = upd_pkg::code_map(code);
                    ent.main.byte_valid = 1'b1;
                    n_phase             = upd_pkg::PH_IDLE;
                end else begin
                    ent.main.decode_error = 1'b1;
                    n_phase               = upd_pkg::PH_DROP;
                end
            end
            upd_pkg::PH_DROP: begin
                // only the string's final byte leaves a marker
                ent.main_present      = i_end_of_string;
                ent.main.decode_error = 1'b1;
            end
            default: begin
                // idle, after %25, or a '2' held after %25
                if (r_phase == upd_pkg::PH_AFTER25 && i_in_byte == upd_pkg::CH_TWO) begin
                    if (i_end_of_string) begin
                        ent.main_present    = 1'b1;
                        ent.main.out_byte   = upd_pkg::CH_TWO;
                        ent.main.byte_valid = 1'b1;
                    end else begin
                        n_phase = upd_pkg::PH_HELD2;
                    end
                end else if (r_phase == upd_pkg::PH_HELD2 &&
                             i_in_byte == upd_pkg::CH_FIVE) begin
                    // dropped "25": marker only when the string ends here
                    ent.main_present = i_end_of_string;
                    n_phase          = upd_pkg::PH_AFTER25;
                end else begin
                    ent.pre_two = (r_phase == upd_pkg::PH_HELD2);
                    if (i_in_byte == upd_pkg::CH_PCT) begin
                        if (i_end_of_string) begin
                            ent.main_present      = 1'b1;
                            ent.main.decode_error = 1'b1;
                        end
                        n_phase = upd_pkg::PH_PCT;
                    end else begin
                        ent.main_present    = 1'b1;
                        ent.main.out_byte   = i_in_byte;
                        ent.main.byte_valid = 1'b1;
                        n_phase             = upd_pkg::PH_IDLE;
                    end
                end
            end
        endcase

        if (i_end_of_string) begin
            n_phase = upd_pkg::PH_IDLE;
            n_hex   = 4'd0;
        end
    end

    assign o_entry = ent;
    assign o_push  = i_accept && (ent.pre_two || ent.main_present);

endmodule

`default_nettype wire

FILE: hdl/upd_queue.sv
`default_nettype none

// Small FIFO of entries between front and back end.
module upd_queue #(
    parameter int DEPTH = upd_pkg::QUEUE_DEPTH
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire upd_pkg::t_entry i_entry,
    input  wire logic            i_pop,
    output upd_pkg::t_entry      o_head,
    output logic                 o_empty,
    output logic                 o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    upd_pkg::t_entry r_mem [DEPTH];
    logic [PW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == FULL_CNT);

endmodule

`default_nettype wire

FILE: hdl/upd_back.sv
`default_nettype none

// Output stage: unpacks an entry into one or two results.
module upd_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire upd_pkg::t_entry i_head,
    input  wire logic            i_empty,
    output logic                 o_pop,
    input  wire logic            i_out_ready,
    output logic                 o_out_valid,
    output upd_pkg::t_result     o_result
);

    logic             r_valid;
    logic             r_sub;     // held '2' of head already sent
    upd_pkg::t_result r_res, n_res;
    logic             load, n_sub;

    assign load = !i_empty && (!r_valid || i_out_ready);

    always_comb begin
        n_res = i_head.main;
        n_sub = 1'b0;
        o_pop = load;
        if (i_head.pre_two && !r_sub) begin
            n_res = '{out_byte: upd_pkg::CH_TWO, byte_valid: 1'b1,
                      decode_error: 1'b0, last_of_string: 1'b0};
            if (i_head.main_present) begin
                n_sub = 1'b1;
                o_pop = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_sub   <= n_sub;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_res;

endmodule

`default_nettype wire

FILE: hdl/uri_percent_decoder_top.sv
`default_nettype none

// Streaming URI percent-decoder. Bytes of a string enter one per item on
// the input channel, the final byte flagged by i_end_of_string. Literal
// bytes pass through; %XX (hex, either case) decodes to the byte when the
// code is accepted (0x20-0x7E, 0x80-0xFF except 81 8D 8F 90 9D AD FE, and
// 0A/0D both giving newline). After %25 the '%' is emitted and directly
// following literal "25" pairs are dropped. A bad hex digit, unknown code
// or truncated escape yields an error item (byte_valid 0, decode_error 1);
// the rest of that string is then dropped, with a closing marker on its
// last byte. Every string's final result carries o_last_of_string.
// Rate: one input item per clock while the queue has room. Each input
// item produces zero, one or two result items; the output port delivers
// one result per clock while i_out_ready is high, so strings that hold
// many "held '2'" cases (two results for one byte) are limited by the
// output side. An accepted item is written into the queue and then loaded
// into the output register before it is offered as a result.
module uri_percent_decoder_top #(
    parameter int QUEUE_DEPTH = upd_pkg::QUEUE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // input channel
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_end_of_string,
    // output channel
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_byte_valid,
    output logic            o_decode_error,
    output logic            o_last_of_string
);

    upd_pkg::t_entry  entry, head;
    upd_pkg::t_result result;
    logic             push, pop, empty, full, accept;

    // Front end is ready whenever the queue has a free slot.
    assign o_in_ready = !full;
    assign accept     = i_in_valid && o_in_ready;

    // Front: escape state machine, classifies each byte.
    upd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_in_byte       (i_in_byte),
        .i_end_of_string (i_end_of_string),
        .o_entry         (entry),
        .o_push          (push)
    );

    // Queue decouples the byte stream from output back-pressure.
    upd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_full  (full)
    );

    // Back: registered output, splits two-result entries.
    upd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_empty     (empty),
        .o_pop       (pop),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_result    (result)
    );

    assign o_out_byte       = result.out_byte;
    assign o_byte_valid     = result.byte_valid;
    assign o_decode_error   = result.decode_error;
    assign o_last_of_string = result.last_of_string;

endmodule

`default_nettype wire
